// ===== rtl/core/dwbm_pkg.sv =====
// ----------------------------------------------------------------------------
// dwbm_pkg
// shared types and constants for the dual window bank mapper
// ----------------------------------------------------------------------------
package dwbm_pkg;

  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_ROM_READ  = 3'd1,
    KIND_RAM_READ  = 3'd2,
    KIND_RAM_WRITE = 3'd3,
    KIND_ZERO      = 3'd4,
    KIND_UNMAPPED  = 3'd5
  } kind_t;

  // flash control bit positions
  localparam int unsigned FL_SELECT = 0;
  localparam int unsigned FL_ENABLE = 1;
  localparam int unsigned FL_TYPE0  = 2;
  localparam int unsigned FL_TYPE1  = 3;

  localparam logic [3:0] RAM_EN_KEY     = 4'hA;
  localparam logic [7:0] FLASH_TYPE_KEY = 8'h08;

  // register file index of cart_has_ram
  localparam logic [1:0] CFG_IDX_CART_HAS_RAM = 2'd0;

  typedef struct packed {
    logic       ram_enabled;
    logic [2:0] ram_bank_low;
    logic [2:0] ram_bank_high;
    logic [6:0] rom_page_low;
    logic [6:0] rom_page_high;
    logic [3:0] flash_bits;
  } bank_state_t;

  typedef struct packed {
    logic       req_type;
    logic [15:0] address;
    logic [7:0] write_value;
  } bus_req_t;

  typedef struct packed {
    kind_t       access_kind;
    logic [19:0] mem_address;
    logic [7:0]  mem_write_data;
    logic [3:0]  flash_status;
  } mem_op_t;

endpackage

// ===== rtl/core/dwbm_decode.sv =====
// ----------------------------------------------------------------------------
// dwbm_decode
// address decode, bank register update and physical address forming
// ----------------------------------------------------------------------------
module dwbm_decode (
  input  dwbm_pkg::bus_req_t    req,
  input  logic                  cart_has_ram,
  input  dwbm_pkg::bank_state_t st,
  output dwbm_pkg::bank_state_t st_nxt,
  output dwbm_pkg::mem_op_t     op
);

  logic       is_wr;
  logic       ram_win;
  logic       rom_win;
  logic       reg_win;
  logic [2:0] ram_bank;
  logic [6:0] rom_page;
  logic       flash_hit;

  assign is_wr   = req.req_type;
  assign ram_win = (req.address[15:13] == 3'b101);
  assign rom_win = (req.address[15:14] == 2'b01);
  assign reg_win = (req.address[15:14] == 2'b00);

  assign ram_bank = req.address[12] ? st.ram_bank_high : st.ram_bank_low;
  assign rom_page = req.address[13] ? st.rom_page_high : st.rom_page_low;

  // window 0 needs select and type0, window 1 needs enable and type1
  assign flash_hit = req.address[13] ?
                     (st.flash_bits[dwbm_pkg::FL_ENABLE] & st.flash_bits[dwbm_pkg::FL_TYPE1]) :
                     (st.flash_bits[dwbm_pkg::FL_SELECT] & st.flash_bits[dwbm_pkg::FL_TYPE0]);

  always_comb begin
    st_nxt            = st;
    op.access_kind    = dwbm_pkg::KIND_NONE;
    op.mem_address    = 20'd0;
    op.mem_write_data = 8'd0;
    if (ram_win) begin
      if (!st.ram_enabled) begin
        op.access_kind = is_wr ? dwbm_pkg::KIND_NONE : dwbm_pkg::KIND_ZERO;
      end else begin
        op.mem_address = {5'd0, ram_bank, req.address[11:0]};
        if (is_wr) begin
          op.access_kind    = dwbm_pkg::KIND_RAM_WRITE;
          op.mem_write_data = req.write_value;
        end else begin
          op.access_kind = dwbm_pkg::KIND_RAM_READ;
        end
      end
    end else if (is_wr) begin
      if (reg_win) begin
        case (req.address[13:10]) inside
          4'd0: begin
            if (req.write_value[3:0] == dwbm_pkg::RAM_EN_KEY) begin
              if (cart_has_ram) begin
                st_nxt.ram_enabled = 1'b1;
              end
            end else begin
              st_nxt.ram_enabled = 1'b0;
            end
          end
          4'd1: st_nxt.ram_bank_low  = req.write_value[2:0];
          4'd2: st_nxt.ram_bank_high = req.write_value[2:0];
          4'd3: st_nxt.flash_bits[dwbm_pkg::FL_SELECT] = req.write_value[0];
          [4'd4:4'd7]: st_nxt.flash_bits[dwbm_pkg::FL_ENABLE] = req.write_value[0];
          [4'd8:4'd9]: st_nxt.rom_page_low = req.write_value[6:0];
          [4'd10:4'd11]: st_nxt.flash_bits[dwbm_pkg::FL_TYPE0] =
                           (req.write_value == dwbm_pkg::FLASH_TYPE_KEY);
          [4'd12:4'd13]: st_nxt.rom_page_high = req.write_value[6:0];
          default: st_nxt.flash_bits[dwbm_pkg::FL_TYPE1] =
                     (req.write_value == dwbm_pkg::FLASH_TYPE_KEY);
        endcase
      end
    end else if (rom_win) begin
      if (flash_hit) begin
        op.access_kind = dwbm_pkg::KIND_ZERO;
      end else begin
        op.access_kind = dwbm_pkg::KIND_ROM_READ;
        op.mem_address = {rom_page, req.address[12:0]};
      end
    end else begin
      op.access_kind = dwbm_pkg::KIND_UNMAPPED;
    end
    op.flash_status = st_nxt.flash_bits;
  end

endmodule

// ===== rtl/core/dual_window_bank_mapper.sv =====
// ----------------------------------------------------------------------------
// dual_window_bank_mapper
// cartridge bank controller: bus access in, physical memory operation out
// ----------------------------------------------------------------------------
// One bus access word in gives one memory operation word out through the
// result register. A new access is taken every cycle: decode and bank
// arithmetic sit in a single layer of logic ahead of the result register,
// and a one-entry skid register behind it keeps in_tready registered, so
// in_tready only drops after the result side has stalled with both entries
// full. Register writes below 0x4000 take effect for the very next access.
module dual_window_bank_mapper (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // address[15:0], write_value[23:16]
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // mem_address[19:0], mem_write_data[27:20],
                                  // flash_status[31:28]
  output logic [2:0]  out_tuser,  // access_kind
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic                  cart_has_ram_r;
  logic                  cart_has_ram_nxt;
  dwbm_pkg::bank_state_t st_r;
  dwbm_pkg::bank_state_t st_nxt;
  dwbm_pkg::bank_state_t dec_st;
  dwbm_pkg::bus_req_t    req;
  dwbm_pkg::mem_op_t     dec_op;
  dwbm_pkg::mem_op_t     out_r;
  dwbm_pkg::mem_op_t     out_nxt;
  dwbm_pkg::mem_op_t     skid_r;
  dwbm_pkg::mem_op_t     skid_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic                  skid_valid_r;
  logic                  skid_valid_nxt;
  logic                  in_acc;
  logic                  cfg_wr;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_prdata = (cfg_paddr == dwbm_pkg::CFG_IDX_CART_HAS_RAM) ?
                      {31'd0, cart_has_ram_r} : 32'd0;

  always_comb begin
    cart_has_ram_nxt = cart_has_ram_r;
    if (cfg_wr && cfg_paddr == dwbm_pkg::CFG_IDX_CART_HAS_RAM) begin
      cart_has_ram_nxt = cfg_pwdata[0];
    end
  end

  // decode
  assign req.req_type    = in_tuser;
  assign req.address     = in_tdata[15:0];
  assign req.write_value = in_tdata[23:16];

  dwbm_decode u_decode (
    .req          (req),
    .cart_has_ram (cart_has_ram_r),
    .st           (st_r),
    .st_nxt       (dec_st),
    .op           (dec_op)
  );

  assign in_tready = ~skid_valid_r;
  assign in_acc    = in_tvalid & in_tready;
  assign st_nxt    = in_acc ? dec_st : st_r;

  // result register with skid entry
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = dec_op;
        out_valid_nxt = in_acc;
      end
    end else if (in_acc) begin
      skid_nxt       = dec_op;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cart_has_ram_r <= 1'b0;
      st_r           <= '0;
      out_valid_r    <= 1'b0;
      skid_valid_r   <= 1'b0;
    end else begin
      cart_has_ram_r <= cart_has_ram_nxt;
      st_r           <= st_nxt;
      out_valid_r    <= out_valid_nxt;
      skid_valid_r   <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.access_kind;
  assign out_tdata  = {out_r.flash_status, out_r.mem_write_data, out_r.mem_address};

endmodule

// ===== rtl/core/dwbm_checker.sv =====
// ----------------------------------------------------------------------------
// dwbm_checker
// port level checks on the result channel of the bank mapper
// ----------------------------------------------------------------------------
module dwbm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= dwbm_pkg::KIND_UNMAPPED)
    else $error("access kind out of range");

  // write data only on ram writes
  a_wdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != dwbm_pkg::KIND_RAM_WRITE |-> out_tdata[27:20] == 8'd0)
    else $error("write data set on a non ram write");

  // no address for operations that touch no memory, ram addresses stay in 15 bits
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == dwbm_pkg::KIND_NONE || out_tuser == dwbm_pkg::KIND_ZERO ||
                   out_tuser == dwbm_pkg::KIND_UNMAPPED) |-> out_tdata[19:0] == 20'd0)
    else $error("address set on an operation without memory access");

  a_ram_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == dwbm_pkg::KIND_RAM_READ ||
                   out_tuser == dwbm_pkg::KIND_RAM_WRITE) |-> out_tdata[19:15] == 5'd0)
    else $error("ram address beyond 15 bits");

endmodule

bind dual_window_bank_mapper dwbm_checker u_dwbm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
